// File: rtl/core/asp_pkg.sv
// Package: shared types and constants for the adjacent-swap permutation generator.
`timescale 1ns / 1ps
`default_nettype none
package asp_pkg;

	localparam int CFG_W = 5;
	localparam int POS_OUT_W = 4;

	typedef enum logic [1:0] {
		PH_RIGHT = 2'd0,
		PH_LEFT  = 2'd1,
		PH_DEFER = 2'd2
	} phase_t;

	typedef struct packed {
		logic restart;
	} req_t;

	typedef struct packed {
		logic                 swap_valid;
		logic [POS_OUT_W-1:0] pos_low;
		logic [POS_OUT_W-1:0] pos_high;
		logic                 finished;
	} rsp_t;

	typedef struct packed {
		logic [CFG_W-1:0] num_elements;
	} cfg_t;

endpackage
`default_nettype wire

// File: rtl/core/asp_if.sv
// Interfaces: request, result and configuration channels with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface asp_req_if;
	import asp_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface asp_rsp_if;
	import asp_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface asp_cfg_if;
	import asp_pkg::*;
	logic valid;
	logic ready;
	cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/adjacent_swap_permutation_gen_unit.sv
// Operation: a request descends one level per cycle from the top level until a
// level takes it and gives a swap result; a request that falls off the bottom
// level exhausts the sequence and answers finished.
// Restart, finished and single-element requests answer without descending.
// Requests: only one is in flight at a time.
// Reset: all levels cleared, num_elements 16 (saturated to MAX_ELEMENTS).
`timescale 1ns / 1ps
`default_nettype none
module adjacent_swap_permutation_gen_unit import asp_pkg::*; #(
	parameter int MAX_ELEMENTS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	asp_req_if.sink   req,
	asp_rsp_if.source rsp,
	asp_cfg_if.sink   cfg
);

	localparam int NL = MAX_ELEMENTS - 1;
	localparam int PW = $clog2(MAX_ELEMENTS);
	localparam int LW = $clog2(2 * MAX_ELEMENTS);
	localparam int NW = $clog2(MAX_ELEMENTS + 1);
	localparam int IW = $clog2(MAX_ELEMENTS);
	localparam int RST_N = (MAX_ELEMENTS < 16) ? MAX_ELEMENTS : 16;

	logic [NW-1:0] eff_q;
	logic [IW-1:0] top_q;
	logic [NW-1:0] eff_new;
	logic          start_q;
	logic          busy_q;
	logic          done_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;
	logic          req_fire;
	logic          cfg_fire;
	logic          clr;

	logic [NL-1:0]         act;
	logic [NL-1:0]         pass;
	logic [NL-1:0][LW-1:0] pass_shift;
	logic [NL-1:0][LW-1:0] shift_in;
	logic [NL-1:0]         hit;
	logic [NL-1:0][LW-1:0] hit_lo;
	logic                  hit_any;
	logic [LW-1:0]         lo_any;
	logic [POS_OUT_W-1:0]  lo_out;

	assign req_fire  = req.valid && req.ready;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign req.ready = !busy_q && (!rsp_valid_q || rsp.ready);
	assign cfg.ready = 1'b1;
	assign clr       = cfg_fire || (req_fire && req.data.restart);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	always_comb begin
		if (cfg.data.num_elements == '0) begin
			eff_new = NW'(1);
		end else if (32'(cfg.data.num_elements) > MAX_ELEMENTS) begin
			eff_new = NW'(MAX_ELEMENTS);
		end else begin
			eff_new = NW'(cfg.data.num_elements);
		end
	end

	// Inject at the top level, or hand down from the cell above.
	generate
		for (genvar i = 0; i < NL; i++) begin : g_cell
			if (i == NL - 1) begin : g_top
				assign act[i]      = start_q && (top_q == IW'(i));
				assign shift_in[i] = '0;
			end else begin : g_mid
				assign act[i]      = (start_q && (top_q == IW'(i))) || pass[i+1];
				assign shift_in[i] = pass[i+1] ? pass_shift[i+1] : '0;
			end
			asp_level_cell #(
				.LEVEL (i),
				.PW    (PW),
				.LW    (LW)
			) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.clr          (clr),
				.act          (act[i]),
				.shift_in     (shift_in[i]),
				.pass_q       (pass[i]),
				.pass_shift_q (pass_shift[i]),
				.hit          (hit[i]),
				.hit_lo       (hit_lo[i])
			);
		end
	endgenerate

	// At most one cell is active, so merge the results by OR.
	always_comb begin
		hit_any = 1'b0;
		lo_any  = '0;
		for (int i = 0; i < NL; i++) begin
			hit_any = hit_any | hit[i];
			lo_any  = lo_any | (hit[i] ? hit_lo[i] : '0);
		end
	end

	assign lo_out = POS_OUT_W'(lo_any);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_q       <= NW'(RST_N);
			top_q       <= IW'(RST_N - 2);
			start_q     <= 1'b0;
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			start_q <= 1'b0;
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_fire) begin
				eff_q  <= eff_new;
				top_q  <= IW'(eff_new - NW'(2));
				done_q <= 1'b0;
			end
			if (req_fire) begin
				if (req.data.restart) begin
					done_q      <= 1'b0;
					rsp_q       <= '0;
					rsp_valid_q <= 1'b1;
				end else if (done_q || eff_q == NW'(1)) begin
					done_q            <= 1'b1;
					rsp_q             <= '0;
					rsp_q.finished    <= 1'b1;
					rsp_valid_q       <= 1'b1;
				end else begin
					start_q <= 1'b1;
					busy_q  <= 1'b1;
				end
			end
			if (busy_q) begin
				if (hit_any) begin
					rsp_q.swap_valid <= 1'b1;
					rsp_q.pos_low    <= lo_out;
					rsp_q.pos_high   <= lo_out + 1'b1;
					rsp_q.finished   <= 1'b0;
					rsp_valid_q      <= 1'b1;
					busy_q           <= 1'b0;
				end else if (pass[0]) begin
					// Request fell off the bottom level: sequence exhausted.
					done_q      <= 1'b1;
					rsp_q       <= '0;
					rsp_q.finished <= 1'b1;
					rsp_valid_q <= 1'b1;
					busy_q      <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/asp_level_cell.sv
// Level cell: sweep position and phase of one level, passes deferred requests down.
`timescale 1ns / 1ps
`default_nettype none
module asp_level_cell import asp_pkg::*; #(
	parameter int LEVEL = 0,
	parameter int PW = 4,
	parameter int LW = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          clr,
	input  wire logic          act,
	input  wire logic [LW-1:0] shift_in,
	output logic               pass_q,
	output logic [LW-1:0]      pass_shift_q,
	output logic               hit,
	output logic [LW-1:0]      hit_lo
);

	// Last position of this level's sweep (level size minus one).
	localparam logic [PW-1:0] LAST = PW'(LEVEL + 1);

	logic [PW-1:0] pos_q;
	logic [PW-1:0] pos_n;
	phase_t        ph_q;
	phase_t        ph_n;
	logic          res_q;
	logic          res_n;
	logic [PW-1:0] lo;
	logic          defer;

	always_comb begin
		pos_n = pos_q;
		ph_n  = ph_q;
		res_n = res_q;
		lo    = '0;
		defer = 1'b0;
		case (ph_q)
			PH_LEFT: begin
				if (pos_q != '0) begin
					pos_n = pos_q - 1'b1;
				end
				if (pos_n == '0) begin
					ph_n  = PH_DEFER;
					res_n = 1'b1;
				end
				lo = pos_n;
			end
			PH_DEFER: begin
				defer = 1'b1;
				ph_n  = res_q ? PH_RIGHT : PH_LEFT;
			end
			default: begin
				if (pos_q < LAST) begin
					pos_n = pos_q + 1'b1;
				end
				if (pos_n == LAST) begin
					ph_n  = PH_DEFER;
					res_n = 1'b0;
				end
				lo = pos_n - 1'b1;
			end
		endcase
	end

	assign hit    = act && !defer;
	assign hit_lo = LW'(lo) + shift_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			ph_q   <= PH_RIGHT;
			res_q  <= 1'b0;
			pass_q <= 1'b0;
		end else if (clr) begin
			pos_q  <= '0;
			ph_q   <= PH_RIGHT;
			res_q  <= 1'b0;
			pass_q <= 1'b0;
		end else begin
			pass_q <= act && defer;
			if (act) begin
				pos_q <= pos_n;
				ph_q  <= ph_n;
				res_q <= res_n;
			end
		end
	end

	// A left sweep just ended: the pair from below moves up by one.
	always_ff @(posedge clk) begin
		pass_shift_q <= shift_in + LW'(res_q);
	end

endmodule
`default_nettype wire

// File: rtl/core/asp_checker.sv
// Checker: port-level properties of the permutation generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module asp_checker import asp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp_data
);

	// Hold a stalled result.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_pair_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.swap_valid |->
			rsp_data.pos_high == rsp_data.pos_low + 4'd1)
		else $error("swap pair not adjacent");

	a_no_swap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.swap_valid |->
			rsp_data.pos_low == '0 && rsp_data.pos_high == '0)
		else $error("positions set without a swap");

	a_swap_not_finished: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_data.swap_valid && rsp_data.finished))
		else $error("swap and finished both set");

endmodule

bind adjacent_swap_permutation_gen_unit asp_checker u_asp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
`default_nettype wire

// File: bench/testbench.sv
// Testbench for the adjacent-swap permutation generator: directed table, then random sequences.
`timescale 1ns / 1ps
module testbench;
	import asp_pkg::*;

	localparam int MAX_ELEMENTS = 16;
	localparam int NUM_LEVELS = MAX_ELEMENTS - 1;
	localparam int RANDOM_ITEMS = 750;
	localparam int IDLE_PCT = 21;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 40;

	localparam rsp_t RSP_ZERO = '{1'b0, 4'd0, 4'd0, 1'b0};
	localparam rsp_t RSP_DONE = '{1'b0, 4'd0, 4'd0, 1'b1};
	localparam rsp_t RSP_SWAP01 = '{1'b1, 4'd0, 4'd1, 1'b0};

	typedef enum logic {
		ROW_REQ = 1'b0,
		ROW_CFG = 1'b1
	} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic [4:0] value;
		logic       typed;
		rsp_t       want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	asp_req_if req_ch();
	asp_rsp_if rsp_ch();
	asp_cfg_if cfg_ch();

	adjacent_swap_permutation_gen_unit #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source),
		.cfg    (cfg_ch.sink)
	);

	always #5ns clk = ~clk;

	// Generator state as the block should hold it.
	logic [3:0] lvl_pos [NUM_LEVELS];
	phase_t     lvl_phase [NUM_LEVELS];
	logic       lvl_resume [NUM_LEVELS];
	logic       exhausted;
	logic [4:0] size_reg;

	rsp_t       pending_swaps [$];
	dir_row_t   dir_rows [$];
	int         mismatches = 0;
	int         items_sent = 0;
	bit         calm = 1'b0;
	bit         rsp_hold_req = 1'b0;

	function automatic void clear_levels();
		for (int i = 0; i < NUM_LEVELS; i++) begin
			lvl_pos[i] = '0;
			lvl_phase[i] = PH_RIGHT;
			lvl_resume[i] = 1'b0;
		end
		exhausted = 1'b0;
	endfunction

	function automatic rsp_t predict_swap(input logic restart_bit);
		rsp_t r;
		int   k;
		int   lvl;
		int   p;
		int   shift;
		int   lo;
		int   hi;
		bit   found;
		r = RSP_ZERO;
		shift = 0;
		lo = 0;
		found = 1'b0;
		if (restart_bit) begin
			clear_levels();
			return r;
		end
		if (exhausted) begin
			r.finished = 1'b1;
			return r;
		end
		k = int'(size_reg);
		if (k == 0)
			k = 1;
		else if (k > MAX_ELEMENTS)
			k = MAX_ELEMENTS;
		while (k >= 2 && !found) begin
			lvl = k - 2;
			p = int'(lvl_pos[lvl]);
			case (lvl_phase[lvl])
				PH_LEFT: begin
					if (p > 0)
						p--;
					if (p == 0) begin
						lvl_phase[lvl] = PH_DEFER;
						lvl_resume[lvl] = 1'b1;
					end
					lvl_pos[lvl] = p[3:0];
					lo = p + shift;
					found = 1'b1;
				end
				PH_DEFER: begin
					// Hand one step down; after a left sweep the lower pair shifts up.
					if (lvl_resume[lvl]) begin
						lvl_phase[lvl] = PH_RIGHT;
						shift++;
					end else begin
						lvl_phase[lvl] = PH_LEFT;
					end
					k--;
				end
				default: begin
					if (p < k - 1)
						p++;
					if (p == k - 1) begin
						lvl_phase[lvl] = PH_DEFER;
						lvl_resume[lvl] = 1'b0;
					end
					lvl_pos[lvl] = p[3:0];
					lo = p - 1 + shift;
					found = 1'b1;
				end
			endcase
		end
		if (found) begin
			hi = lo + 1;
			r.swap_valid = 1'b1;
			r.pos_low = lo[3:0];
			r.pos_high = hi[3:0];
		end else begin
			exhausted = 1'b1;
			r.finished = 1'b1;
		end
		return r;
	endfunction

	task automatic send_request(input logic restart_bit, input logic typed, input rsp_t want);
		rsp_t got;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data.restart <= restart_bit;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		got = predict_swap(restart_bit);
		pending_swaps.push_back(typed ? want : got);
		items_sent++;
	endtask

	// Drop the request line and hold until every result is back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_swaps.size() != 0);
	endtask

	task automatic write_size(input logic [4:0] value);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data.num_elements <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		size_reg = value;
		clear_levels();
	endtask

	task automatic add_row(input row_kind_t kind, input logic [4:0] value,
			input logic typed, input rsp_t want);
		dir_row_t row;
		row.kind = kind;
		row.value = value;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endtask

	task automatic check_result(input rsp_t got);
		rsp_t want;
		if (pending_swaps.size() == 0) begin
			if (mismatches < 10)
				$display("unexpected result: v=%0d lo=%0d hi=%0d fin=%0d",
					got.swap_valid, got.pos_low, got.pos_high, got.finished);
			mismatches++;
		end else begin
			want = pending_swaps.pop_front();
			if (got.swap_valid !== want.swap_valid || got.pos_low !== want.pos_low ||
					got.pos_high !== want.pos_high || got.finished !== want.finished) begin
				if (mismatches < 10)
					$display({"swap mismatch: expected v=%0d lo=%0d hi=%0d fin=%0d,",
						" got v=%0d lo=%0d hi=%0d fin=%0d"},
						want.swap_valid, want.pos_low, want.pos_high, want.finished,
						got.swap_valid, got.pos_low, got.pos_high, got.finished);
				mismatches++;
			end
		end
	endtask

	// Result side: check accepted results and pick ready for the next cycle.
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				check_result(rsp_ch.data);
			if (rsp_hold_req) begin
				rsp_hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		#5ms;
		$display("[adjacent_swap_permutation_gen_unit] ERROR");
		$finish;
	end

	initial begin
		int         seq_len;
		int         count;
		int         roll;
		bit         held;
		bit         paused;
		logic [4:0] n;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		size_reg = 5'd16;
		clear_levels();
		held = 1'b0;
		paused = 1'b0;

		add_row(ROW_REQ, 5'd0, 1'b1, RSP_SWAP01);
		add_row(ROW_REQ, 5'd0, 1'b0, RSP_ZERO);
		add_row(ROW_REQ, 5'd1, 1'b1, RSP_ZERO);
		add_row(ROW_REQ, 5'd0, 1'b1, RSP_SWAP01);
		add_row(ROW_CFG, 5'd1, 1'b0, RSP_ZERO);
		add_row(ROW_REQ, 5'd0, 1'b1, RSP_DONE);
		add_row(ROW_REQ, 5'd0, 1'b1, RSP_DONE);
		add_row(ROW_REQ, 5'd1, 1'b1, RSP_ZERO);
		add_row(ROW_REQ, 5'd0, 1'b1, RSP_DONE);
		add_row(ROW_CFG, 5'd0, 1'b0, RSP_ZERO);
		add_row(ROW_REQ, 5'd0, 1'b1, RSP_DONE);
		add_row(ROW_CFG, 5'd2, 1'b0, RSP_ZERO);
		add_row(ROW_REQ, 5'd0, 1'b1, RSP_SWAP01);
		add_row(ROW_REQ, 5'd0, 1'b1, RSP_DONE);
		add_row(ROW_REQ, 5'd0, 1'b1, RSP_DONE);
		add_row(ROW_CFG, 5'd3, 1'b0, RSP_ZERO);
		for (int i = 0; i < 6; i++)
			add_row(ROW_REQ, 5'd0, 1'b0, RSP_ZERO);
		add_row(ROW_REQ, 5'd1, 1'b1, RSP_ZERO);
		add_row(ROW_REQ, 5'd0, 1'b1, RSP_SWAP01);
		add_row(ROW_CFG, 5'd31, 1'b0, RSP_ZERO);
		add_row(ROW_REQ, 5'd0, 1'b1, RSP_SWAP01);
		add_row(ROW_REQ, 5'd0, 1'b0, RSP_ZERO);
		add_row(ROW_CFG, 5'd17, 1'b0, RSP_ZERO);
		add_row(ROW_REQ, 5'd0, 1'b0, RSP_ZERO);
		add_row(ROW_REQ, 5'd0, 1'b0, RSP_ZERO);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				write_size(dir_rows[i].value);
			else
				send_request(dir_rows[i].value[0], dir_rows[i].typed, dir_rows[i].want);
		end

		// Mostly small sizes so that whole sequences run out; a few large ones.
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			roll = $urandom_range(99);
			if (roll < 10)
				n = 5'($urandom_range(1, 0));
			else if (roll < 40)
				n = 5'($urandom_range(3, 2));
			else if (roll < 70)
				n = 5'd4;
			else if (roll < 85)
				n = 5'd5;
			else
				n = 5'($urandom_range(31, 6));
			case (n)
				5'd2: seq_len = 2;
				5'd3: seq_len = 6;
				5'd4: seq_len = 24;
				5'd5: seq_len = 120;
				default: seq_len = (n < 2) ? 1 : $urandom_range(40, 10);
			endcase
			count = seq_len + $urandom_range(4, 1);
			write_size(n);
			for (int j = 0; j < count && items_sent < RANDOM_ITEMS; j++) begin
				if (!held && items_sent >= 200) begin
					held = 1'b1;
					rsp_hold_req = 1'b1;
				end
				if (!paused && items_sent >= 450) begin
					paused = 1'b1;
					drain();
				end
				calm = (items_sent >= 500 && items_sent < 620);
				send_request($urandom_range(99) < 3, 1'b0, RSP_ZERO);
			end
		end
		calm = 1'b0;

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_swaps.size() == 0)
			$display("[adjacent_swap_permutation_gen_unit] OK");
		else
			$display("[adjacent_swap_permutation_gen_unit] ERROR");
		$finish;
	end

endmodule
